### rtl/button_auto_repeat_tracker_assert.svh
// assertion macros shared by the tracker
`ifndef BUTTON_AUTO_REPEAT_TRACKER_ASSERT_SVH
`define BUTTON_AUTO_REPEAT_TRACKER_ASSERT_SVH

// same-cycle implication
`define BART_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define BART_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

### rtl/bart_pkg.sv
`timescale 1ns / 1ps

package bart_pkg;

   localparam int CHANNELS_DEF      = 4;
   localparam int DURATION_BITS_DEF = 24;

   localparam int PIN_BITS        = 4;
   localparam int QUERY_BITS      = 2;
   localparam int COUNT_BITS      = 3;
   localparam int REPEAT_BITS     = 16;
   localparam int THRESH_BITS     = 16;
   localparam int RESULT_DUR_BITS = 24;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [THRESH_BITS-1:0] FIRST_DEF  = THRESH_BITS'(60);
   localparam logic [THRESH_BITS-1:0] SECOND_DEF = THRESH_BITS'(250);
   localparam logic [THRESH_BITS-1:0] STEADY_DEF = THRESH_BITS'(200);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ENABLE,
      REG_FIRST,
      REG_SECOND,
      REG_STEADY
   } csr_reg_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0] first;
      logic [THRESH_BITS-1:0] second;
      logic [THRESH_BITS-1:0] steady;
   } thresholds_type;

   typedef struct packed {
      logic held;
      logic released;
      logic press_pulse;
      logic rel_pulse;
      logic rpt_pulse;
   } lane_flags_type;

   typedef struct packed {
      logic [PIN_BITS-1:0]        held_mask;
      logic [PIN_BITS-1:0]        released_mask;
      logic [PIN_BITS-1:0]        press_pulse_mask;
      logic [PIN_BITS-1:0]        release_pulse_mask;
      logic [PIN_BITS-1:0]        repeat_pulse_mask;
      logic [COUNT_BITS-1:0]      held_count;
      logic [REPEAT_BITS-1:0]     query_repeats;
      logic [RESULT_DUR_BITS-1:0] query_held_ticks;
      logic [RESULT_DUR_BITS-1:0] query_released_ticks;
   } rsp_item_type;

endpackage

### rtl/bart_req_if.sv
`timescale 1ns / 1ps

interface bart_req_if import bart_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIN_BITS-1:0]   pin_levels;
   logic [QUERY_BITS-1:0] query_channel;

   modport source (output valid, output pin_levels, output query_channel, input ready);
   modport sink   (input valid, input pin_levels, input query_channel, output ready);
endinterface

### rtl/bart_rsp_if.sv
`timescale 1ns / 1ps

interface bart_rsp_if import bart_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [PIN_BITS-1:0]        held_mask;
   logic [PIN_BITS-1:0]        released_mask;
   logic [PIN_BITS-1:0]        press_pulse_mask;
   logic [PIN_BITS-1:0]        release_pulse_mask;
   logic [PIN_BITS-1:0]        repeat_pulse_mask;
   logic [COUNT_BITS-1:0]      held_count;
   logic [REPEAT_BITS-1:0]     query_repeats;
   logic [RESULT_DUR_BITS-1:0] query_held_ticks;
   logic [RESULT_DUR_BITS-1:0] query_released_ticks;

   modport source (
      output valid, output held_mask, output released_mask, output press_pulse_mask,
      output release_pulse_mask, output repeat_pulse_mask, output held_count,
      output query_repeats, output query_held_ticks, output query_released_ticks,
      input ready
   );
   modport sink (
      input valid, input held_mask, input released_mask, input press_pulse_mask,
      input release_pulse_mask, input repeat_pulse_mask, input held_count,
      input query_repeats, input query_held_ticks, input query_released_ticks,
      output ready
   );
endinterface

### rtl/button_auto_repeat_tracker.sv
`timescale 1ns / 1ps
//  channel  direction  handshake          payload
//  req_if   in         valid / ready      pin_levels, query_channel
//  rsp_if   out        valid / ready      masks, held_count, query counters
//  csr_*    in         csr_wr_en only     csr_index, csr_data
//
//  one tick per cycle while req_if.ready is high; each tick's result is registered
//  per-channel lanes update in parallel, the merge stage folds them into one item
//  an output register plus one skid slot keep req_if ready while a result waits
//  req_if.ready drops only when both slots are full
//  synchronous reset restores the default thresholds with enable set and clears all lanes

module button_auto_repeat_tracker import bart_pkg::*; #(
   parameter int CHANNELS      = CHANNELS_DEF,
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   bart_req_if.sink                  req_if,
   bart_rsp_if.source                rsp_if,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

`include "button_auto_repeat_tracker_assert.svh"

   logic           enable_ff, enable_in;
   thresholds_type thr_ff, thr_in;
   logic           thr_clear;
   logic           accept;

   lane_flags_type           lane_flags [CHANNELS];
   logic [REPEAT_BITS-1:0]   lane_rep   [CHANNELS];
   logic [DURATION_BITS-1:0] lane_held  [CHANNELS];
   logic [DURATION_BITS-1:0] lane_rel   [CHANNELS];

   rsp_item_type rsp_item;

   // register decode
   always_comb begin
      enable_in = enable_ff;
      thr_in    = thr_ff;
      thr_clear = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_ENABLE: enable_in = csr_data[0];
            REG_FIRST: begin
               thr_in.first = csr_data[THRESH_BITS-1:0];
               thr_clear    = 1'b1;
            end
            REG_SECOND: begin
               thr_in.second = csr_data[THRESH_BITS-1:0];
               thr_clear     = 1'b1;
            end
            REG_STEADY: begin
               thr_in.steady = csr_data[THRESH_BITS-1:0];
               thr_clear     = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         thr_ff.first  <= FIRST_DEF;
         thr_ff.second <= SECOND_DEF;
         thr_ff.steady <= STEADY_DEF;
      end else begin
         enable_ff <= enable_in;
         thr_ff    <= thr_in;
      end
   end

   assign accept = req_if.valid && req_if.ready;

   // one lane per channel; channels without a pin always read released
   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      logic pin;
      if (g < PIN_BITS) begin : g_pin
         assign pin = req_if.pin_levels[g];
      end else begin : g_nopin
         assign pin = 1'b0;
      end

      bart_lane #(
         .DURATION_BITS (DURATION_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .clear      (thr_clear),
         .pin        (pin),
         .thresholds (thr_ff),
         .flags      (lane_flags[g]),
         .rep_count  (lane_rep[g]),
         .held_dur   (lane_held[g]),
         .rel_dur    (lane_rel[g])
      );
   end

   bart_merge #(
      .CHANNELS      (CHANNELS),
      .DURATION_BITS (DURATION_BITS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .push          (accept),
      .enable        (enable_ff),
      .query_channel (req_if.query_channel),
      .flags         (lane_flags),
      .rep_count     (lane_rep),
      .held_dur      (lane_held),
      .rel_dur       (lane_rel),
      .out_ready     (rsp_if.ready),
      .in_ready      (req_if.ready),
      .out_valid     (rsp_if.valid),
      .out_item      (rsp_item)
   );

   assign rsp_if.held_mask            = rsp_item.held_mask;
   assign rsp_if.released_mask        = rsp_item.released_mask;
   assign rsp_if.press_pulse_mask     = rsp_item.press_pulse_mask;
   assign rsp_if.release_pulse_mask   = rsp_item.release_pulse_mask;
   assign rsp_if.repeat_pulse_mask    = rsp_item.repeat_pulse_mask;
   assign rsp_if.held_count           = rsp_item.held_count;
   assign rsp_if.query_repeats        = rsp_item.query_repeats;
   assign rsp_if.query_held_ticks     = rsp_item.query_held_ticks;
   assign rsp_if.query_released_ticks = rsp_item.query_released_ticks;

   // an empty output register means the skid slot is empty too
   `BART_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_if.valid, req_if.ready,
                    "input not ready with empty output")

   // an item taken behind a stalled result fills the skid slot
   `BART_ASSERT_NEXT(a_skid_fills, clock, reset, accept && rsp_if.valid && !rsp_if.ready,
                     !req_if.ready, "skid slot not filled")

   // disabled ticks report all zero
   `BART_ASSERT_NEXT(a_disabled_zero, clock, reset, accept && !rsp_if.valid && !enable_ff,
                     rsp_if.held_mask == '0 && rsp_if.query_repeats == '0 &&
                     rsp_if.query_held_ticks == '0, "disabled item not zero")

endmodule

### rtl/bart_lane.sv
`timescale 1ns / 1ps

module bart_lane import bart_pkg::*; #(
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     clear,
   input  logic                     pin,
   input  thresholds_type           thresholds,
   output lane_flags_type           flags,
   output logic [REPEAT_BITS-1:0]   rep_count,
   output logic [DURATION_BITS-1:0] held_dur,
   output logic [DURATION_BITS-1:0] rel_dur
);

   logic                     held_ff, held_in;
   logic                     released_ff, released_in;
   logic [THRESH_BITS-1:0]   hold_cnt_ff, hold_cnt_in;
   logic [REPEAT_BITS-1:0]   rep_cnt_ff, rep_cnt_in;
   logic [DURATION_BITS-1:0] held_dur_ff, held_dur_in;
   logic [DURATION_BITS-1:0] rel_dur_ff, rel_dur_in;

   logic [THRESH_BITS-1:0]   hold_inc;
   logic [THRESH_BITS-1:0]   thr;
   logic                     rpt_hit;

   always_comb begin
      hold_inc = (hold_cnt_ff == '1) ? hold_cnt_ff : hold_cnt_ff + THRESH_BITS'(1);
      if (rep_cnt_ff == REPEAT_BITS'(0)) begin
         thr = thresholds.first;
      end else if (rep_cnt_ff == REPEAT_BITS'(1)) begin
         thr = thresholds.second;
      end else begin
         thr = thresholds.steady;
      end
      rpt_hit = (hold_inc >= thr);

      flags.press_pulse = 1'b0;
      flags.rel_pulse   = 1'b0;
      flags.rpt_pulse   = 1'b0;
      held_dur_in       = held_dur_ff;
      rel_dur_in        = rel_dur_ff;
      if (pin) begin
         flags.press_pulse = !held_ff;
         held_dur_in = !held_ff ? '0 :
                       (held_dur_ff == '1) ? held_dur_ff : held_dur_ff + DURATION_BITS'(1);
         held_in     = 1'b1;
         released_in = 1'b0;
         flags.rpt_pulse = rpt_hit;
         hold_cnt_in = rpt_hit ? '0 : hold_inc;
         rep_cnt_in  = (rpt_hit && rep_cnt_ff != '1) ? rep_cnt_ff + REPEAT_BITS'(1)
                                                     : rep_cnt_ff;
      end else begin
         flags.rel_pulse = held_ff;
         rel_dur_in = held_ff ? '0 :
                      (rel_dur_ff == '1) ? rel_dur_ff : rel_dur_ff + DURATION_BITS'(1);
         held_in     = 1'b0;
         released_in = 1'b1;
         hold_cnt_in = '0;
         rep_cnt_in  = '0;
      end
      flags.held     = held_in;
      flags.released = released_in;
   end

   assign rep_count = rep_cnt_in;
   assign held_dur  = held_dur_in;
   assign rel_dur   = rel_dur_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= 1'b0;
         released_ff <= 1'b0;
         hold_cnt_ff <= '0;
         rep_cnt_ff  <= '0;
         held_dur_ff <= '0;
         rel_dur_ff  <= '0;
      end else begin
         if (accept) begin
            held_ff     <= held_in;
            released_ff <= released_in;
            hold_cnt_ff <= hold_cnt_in;
            rep_cnt_ff  <= rep_cnt_in;
            held_dur_ff <= held_dur_in;
            rel_dur_ff  <= rel_dur_in;
         end
         // threshold write restarts every repeat sequence
         if (clear) begin
            hold_cnt_ff <= '0;
            rep_cnt_ff  <= '0;
         end
      end
   end

endmodule

### rtl/bart_merge.sv
`timescale 1ns / 1ps

module bart_merge import bart_pkg::*; #(
   parameter int CHANNELS      = CHANNELS_DEF,
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic                     enable,
   input  logic [QUERY_BITS-1:0]    query_channel,
   input  lane_flags_type           flags     [CHANNELS],
   input  logic [REPEAT_BITS-1:0]   rep_count [CHANNELS],
   input  logic [DURATION_BITS-1:0] held_dur  [CHANNELS],
   input  logic [DURATION_BITS-1:0] rel_dur   [CHANNELS],
   input  logic                     out_ready,
   output logic                     in_ready,
   output logic                     out_valid,
   output rsp_item_type             out_item
);

   rsp_item_type item;
   logic         pop;

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_ff, skid_in;

   // combine lane results into one item
   always_comb begin
      item = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (i < PIN_BITS) begin
            item.held_mask[i]          = flags[i].held;
            item.released_mask[i]      = flags[i].released;
            item.press_pulse_mask[i]   = flags[i].press_pulse;
            item.release_pulse_mask[i] = flags[i].rel_pulse;
            item.repeat_pulse_mask[i]  = flags[i].rpt_pulse;
            item.held_count = item.held_count + COUNT_BITS'(flags[i].held);
         end
         if (i < (2 ** QUERY_BITS) && query_channel == QUERY_BITS'(i)) begin
            item.query_repeats        = rep_count[i];
            item.query_held_ticks     = RESULT_DUR_BITS'(held_dur[i]);
            item.query_released_ticks = RESULT_DUR_BITS'(rel_dur[i]);
         end
      end
      if (!enable) begin
         item = '0;
      end
   end

   // output register with a skid slot behind it
   assign pop      = out_valid_ff && out_ready;
   assign in_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = push;
            skid_in       = item;
         end else begin
            out_valid_in = push;
            out_in       = item;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule

### tb/bart_checker.sv
`timescale 1ns / 1ps

module bart_checker import bart_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   bart_req_if                       req_mon,
   bart_rsp_if                       rsp_mon,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        fail_count,
   output int                        pending_count
);

   localparam logic [DURATION_BITS_DEF-1:0] DUR_MAX = '1;
   localparam logic [REPEAT_BITS-1:0]       RPT_MAX = '1;
   localparam logic [THRESH_BITS-1:0]       HOLD_MAX = '1;

   // shadow of the block's registers
   logic                   report_enable;
   logic [THRESH_BITS-1:0] first_limit;
   logic [THRESH_BITS-1:0] second_limit;
   logic [THRESH_BITS-1:0] steady_limit;

   // shadow of the per-channel state
   logic                         is_held      [CHANNELS_DEF];
   logic                         was_released [CHANNELS_DEF];
   logic [THRESH_BITS-1:0]       hold_ticks   [CHANNELS_DEF];
   logic [REPEAT_BITS-1:0]       repeats      [CHANNELS_DEF];
   logic [DURATION_BITS_DEF-1:0] held_ticks   [CHANNELS_DEF];
   logic [DURATION_BITS_DEF-1:0] idle_ticks   [CHANNELS_DEF];

   rsp_item_type expected_reports[$];

   task automatic clear_channels();
      int n;
      for (n = 0; n < CHANNELS_DEF; n++) begin
         is_held[n]      = 1'b0;
         was_released[n] = 1'b0;
         hold_ticks[n]   = '0;
         repeats[n]      = '0;
         held_ticks[n]   = '0;
         idle_ticks[n]   = '0;
      end
   endtask

   // one tick of the tracker: updates the shadow state, returns the report
   task automatic advance_channels(input logic [PIN_BITS-1:0] pins,
                                   input logic [QUERY_BITS-1:0] query,
                                   output rsp_item_type report);
      int n;
      logic [THRESH_BITS-1:0] limit;
      report = '0;
      for (n = 0; n < CHANNELS_DEF; n++) begin
         if (pins[n]) begin
            if (!is_held[n]) begin
               report.press_pulse_mask[n] = 1'b1;
               held_ticks[n] = '0;
            end else if (held_ticks[n] != DUR_MAX) begin
               held_ticks[n] = held_ticks[n] + 1'b1;
            end
            is_held[n] = 1'b1;
            if (hold_ticks[n] != HOLD_MAX)
               hold_ticks[n] = hold_ticks[n] + 1'b1;
            if (repeats[n] == 0)
               limit = first_limit;
            else if (repeats[n] == 1)
               limit = second_limit;
            else
               limit = steady_limit;
            if (hold_ticks[n] >= limit) begin
               hold_ticks[n] = '0;
               if (repeats[n] != RPT_MAX)
                  repeats[n] = repeats[n] + 1'b1;
               report.repeat_pulse_mask[n] = 1'b1;
            end
            was_released[n] = 1'b0;
         end else begin
            if (is_held[n]) begin
               report.release_pulse_mask[n] = 1'b1;
               idle_ticks[n] = '0;
            end else if (idle_ticks[n] != DUR_MAX) begin
               idle_ticks[n] = idle_ticks[n] + 1'b1;
            end
            is_held[n]      = 1'b0;
            was_released[n] = 1'b1;
            repeats[n]      = '0;
            hold_ticks[n]   = '0;
         end
         if (is_held[n]) begin
            report.held_mask[n] = 1'b1;
            report.held_count   = report.held_count + 1'b1;
         end
         if (was_released[n])
            report.released_mask[n] = 1'b1;
      end
      if (int'(query) < CHANNELS_DEF) begin
         report.query_repeats        = repeats[query];
         report.query_held_ticks     = RESULT_DUR_BITS'(held_ticks[query]);
         report.query_released_ticks = RESULT_DUR_BITS'(idle_ticks[query]);
      end
      if (!report_enable)
         report = '0;
   endtask

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s expected %0h actual %0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type predicted;
      rsp_item_type observed;
      csr_reg_type  reg_sel;
      int           n;
      if (reset) begin
         report_enable = 1'b1;
         first_limit   = FIRST_DEF;
         second_limit  = SECOND_DEF;
         steady_limit  = STEADY_DEF;
         clear_channels();
         expected_reports.delete();
      end else begin
         // register writes must land only when no item moves; not enforced
         if (csr_wr_en) begin
            reg_sel = csr_reg_type'(csr_index);
            if (reg_sel == REG_ENABLE) begin
               report_enable = csr_data[0];
            end else begin
               case (reg_sel)
                  REG_FIRST:  first_limit  = csr_data;
                  REG_SECOND: second_limit = csr_data;
                  default:    steady_limit = csr_data;
               endcase
               // any threshold write restarts every repeat sequence
               for (n = 0; n < CHANNELS_DEF; n++) begin
                  hold_ticks[n] = '0;
                  repeats[n]    = '0;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            advance_channels(req_mon.pin_levels, req_mon.query_channel, predicted);
            expected_reports.push_back(predicted);
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.held_mask            = rsp_mon.held_mask;
            observed.released_mask        = rsp_mon.released_mask;
            observed.press_pulse_mask     = rsp_mon.press_pulse_mask;
            observed.release_pulse_mask   = rsp_mon.release_pulse_mask;
            observed.repeat_pulse_mask    = rsp_mon.repeat_pulse_mask;
            observed.held_count           = rsp_mon.held_count;
            observed.query_repeats        = rsp_mon.query_repeats;
            observed.query_held_ticks     = rsp_mon.query_held_ticks;
            observed.query_released_ticks = rsp_mon.query_released_ticks;
            if (expected_reports.size() == 0) begin
               $error("report arrived with no tick pending");
               fail_count++;
            end else begin
               predicted = expected_reports.pop_front();
               check_field("held_mask", predicted.held_mask, observed.held_mask);
               check_field("released_mask", predicted.released_mask,
                           observed.released_mask);
               check_field("press_pulse_mask", predicted.press_pulse_mask,
                           observed.press_pulse_mask);
               check_field("release_pulse_mask", predicted.release_pulse_mask,
                           observed.release_pulse_mask);
               check_field("repeat_pulse_mask", predicted.repeat_pulse_mask,
                           observed.repeat_pulse_mask);
               check_field("held_count", predicted.held_count, observed.held_count);
               check_field("query_repeats", predicted.query_repeats,
                           observed.query_repeats);
               check_field("query_held_ticks", predicted.query_held_ticks,
                           observed.query_held_ticks);
               check_field("query_released_ticks", predicted.query_released_ticks,
                           observed.query_released_ticks);
            end
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bart_pkg::*;

   localparam int LONG_STALL  = 40;   // receiver hold-off, long enough to fill both slots
   localparam int PHASE_ITEMS = 80;   // random ticks per idling phase
   localparam int HOLD_TICKS  = 20;   // one unbroken hold on channel 0

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   bart_req_if req_ch();
   bart_rsp_if rsp_ch();

   int fail_count;
   int pending_count;

   // idling knobs, percent of cycles
   int   req_gap_pct = 0;
   int   stall_pct   = 0;
   // toggled to ask the receiver process for one long hold-off
   logic stall_trigger = 1'b0;

   // button sequence generator state: current level and ticks left per channel
   logic [PIN_BITS-1:0] live_pins = '0;
   int                  run_left[PIN_BITS];

   always #5 clock = ~clock;

   button_auto_repeat_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   bart_checker report_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // hard stop well past the slowest legal run
   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off counted here on request
   initial begin
      logic stall_seen;
      int   stall_left;
      stall_seen   = 1'b0;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_trigger != stall_seen) begin
            stall_seen = stall_trigger;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one tick, hold it until taken; starts and ends at a falling edge
   task automatic send_tick(input logic [PIN_BITS-1:0] pins,
                            input logic [QUERY_BITS-1:0] query);
      while ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      // valid stays high across back-to-back ticks, no drop in between
      req_ch.valid         <= 1'b1;
      req_ch.pin_levels    <= pins;
      req_ch.query_channel <= query;
      forever begin
         @(posedge clock);
         if (req_ch.ready)
            break;
      end
      @(negedge clock);
   endtask

   // stop offering and wait for every pending report, then let the pipe settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one register write, then csr_wr_en drops so the enable never re-rises in a step
   task automatic write_reg(input csr_reg_type sel, input logic [CSR_DATA_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [THRESH_BITS-1:0] first,
                             input logic [THRESH_BITS-1:0] second,
                             input logic [THRESH_BITS-1:0] steady);
      write_reg(REG_FIRST, first);
      write_reg(REG_SECOND, second);
      write_reg(REG_STEADY, steady);
   endtask

   // mostly realistic press and release runs per channel, some pure noise ticks
   task automatic next_pins(output logic [PIN_BITS-1:0] pins);
      int n;
      if ($urandom_range(99) < 15) begin
         pins = PIN_BITS'($urandom);
      end else begin
         for (n = 0; n < PIN_BITS; n++) begin
            if (run_left[n] == 0) begin
               live_pins[n] = ~live_pins[n];
               run_left[n]  = ($urandom_range(3) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(1, 6);
            end
            run_left[n]--;
         end
         pins = live_pins;
      end
   endtask

   task automatic run_random(input int count);
      logic [PIN_BITS-1:0] pins;
      repeat (count) begin
         next_pins(pins);
         send_tick(pins, QUERY_BITS'($urandom_range(3)));
      end
   endtask

   initial begin
      int n;
      req_ch.valid         = 1'b0;
      req_ch.pin_levels    = '0;
      req_ch.query_channel = '0;
      csr_wr_en            = 1'b0;
      csr_index            = REG_ENABLE;
      csr_data             = '0;
      for (n = 0; n < PIN_BITS; n++)
         run_left[n] = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: default thresholds, idle pins, all pressed, partial release
      send_tick(4'h0, 2'd0);
      send_tick(4'hF, 2'd0);
      send_tick(4'hF, 2'd1);
      send_tick(4'hF, 2'd2);
      send_tick(4'hF, 2'd3);
      send_tick(4'h5, 2'd0);
      send_tick(4'hA, 2'd1);
      send_tick(4'h0, 2'd2);

      // short thresholds: first, second and steady repeats while held, then release
      wait_drained();
      set_limits(16'd2, 16'd3, 16'd1);
      for (n = 0; n < 12; n++)
         send_tick(4'hF, QUERY_BITS'(n));
      send_tick(4'h0, 2'd3);

      // disabled: state keeps moving but every report field reads zero
      wait_drained();
      write_reg(REG_ENABLE, 16'h0000);
      send_tick(4'hF, 2'd0);
      send_tick(4'hF, 2'd1);
      send_tick(4'h0, 2'd2);
      wait_drained();
      write_reg(REG_ENABLE, 16'h0001);

      // zero thresholds repeat on every held tick
      set_limits(16'd0, 16'd0, 16'd0);
      send_tick(4'h3, 2'd0);
      send_tick(4'h3, 2'd1);
      send_tick(4'h3, 2'd0);
      send_tick(4'h0, 2'd1);

      // no idling; opens with a long receiver hold-off so the input backs up
      wait_drained();
      set_limits(16'd2, 16'd4, 16'd3);
      req_gap_pct = 0;
      stall_pct   = 0;
      stall_trigger <= ~stall_trigger;
      run_random(PHASE_ITEMS / 2);
      // sender pauses until every report is back
      wait_drained();
      run_random(PHASE_ITEMS - PHASE_ITEMS / 2);

      // sender mostly idle, smallest nonzero thresholds
      wait_drained();
      set_limits(16'd1, 16'd1, 16'd1);
      req_gap_pct = 87;
      stall_pct   = 0;
      run_random(PHASE_ITEMS);

      // receiver mostly stalled, largest thresholds
      wait_drained();
      set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
      req_gap_pct = 0;
      stall_pct   = 87;
      run_random(PHASE_ITEMS);

      // light idling on both sides
      wait_drained();
      set_limits(16'd3, 16'd1, 16'd2);
      req_gap_pct = 11;
      stall_pct   = 11;
      run_random(PHASE_ITEMS);

      // one unbroken hold: first repeat after a few ticks, then one every tick
      wait_drained();
      set_limits(16'd5, 16'd0, 16'd0);
      req_gap_pct = 0;
      stall_pct   = 0;
      for (n = 0; n < HOLD_TICKS; n++)
         send_tick(4'h1, QUERY_BITS'($urandom_range(3)));
      send_tick(4'h0, 2'd0);

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
